FILE: rtl/takeoff_sequencer_velocity_limiter_unit_defines.svh
// Assertion macros shared by the RTL of the take-off sequencer.
// Each macro expects clk and rst to be visible in the module that uses it.
`ifndef TAKEOFF_SEQUENCER_VELOCITY_LIMITER_UNIT_DEFINES_SVH
`define TAKEOFF_SEQUENCER_VELOCITY_LIMITER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TSVL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define TSVL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TSVL_ASSERT_IMPL(lbl, ante, cons, msg)
`define TSVL_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/tsvl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tsvl_pkg;

  // input word modes
  localparam logic [1:0] MODE_SEQ  = 2'd0;
  localparam logic [1:0] MODE_BEAT = 2'd1;
  localparam logic [1:0] MODE_CMD  = 2'd2;

  // vehicle command kinds
  localparam logic CMD_ARM      = 1'b0;
  localparam logic CMD_OFFBOARD = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE_HEIGHT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_H_SPEED   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_V_SPEED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_GAIN   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CMD_TIMEOUT   = 3'd4;
  localparam int unsigned CFG_DATA_W = 16;

  // sequencer timing and altitude constants
  localparam logic [4:0] STREAM_TICKS   = 5'd10;
  localparam logic [4:0] ARM_TICK_LIMIT = 5'd25;
  localparam logic signed [16:0] NEAR_LIMIT = 17'sd76;  // 0.3 m in Q8.8
  localparam logic signed [29:0] ROUND_HALF = 30'sd128;

  // reset values of the configuration
  localparam logic [14:0] RST_CRUISE_HEIGHT = 15'd768;
  localparam logic [14:0] RST_MAX_H_SPEED   = 15'd512;
  localparam logic [14:0] RST_MAX_V_SPEED   = 15'd256;
  localparam logic [11:0] RST_HEIGHT_GAIN   = 12'd128;
  localparam logic [15:0] RST_CMD_TIMEOUT   = 16'd20;

  typedef enum logic [2:0] {
    PH_WAIT   = 3'd0,
    PH_STREAM = 3'd1,
    PH_ARM    = 3'd2,
    PH_CLIMB  = 3'd3,
    PH_CRUISE = 3'd4
  } phase_t;

  typedef struct packed {
    logic [14:0] cruise_height;
    logic [14:0] max_h_speed;
    logic [14:0] max_v_speed;
    logic [11:0] height_gain;
    logic [15:0] cmd_timeout;
  } cfg_t;

  // one classified word from the front to the back
  typedef struct packed {
    logic               hb;     // heartbeat sent
    logic               sp;     // setpoint sent
    logic               alt;    // vz from the altitude law
    logic               vel;    // held command is fresh
    logic               ce;     // vehicle command sent
    logic               ck;     // vehicle command kind
    phase_t             phase;
    logic signed [16:0] err;    // height error, Q8.8
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] yr;
  } job_t;

endpackage

`default_nettype wire

FILE: rtl/tsvl_front.sv
`timescale 1ns / 1ps
`default_nettype none

`include "takeoff_sequencer_velocity_limiter_unit_defines.svh"

module tsvl_front import tsvl_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         mode,
  input  wire logic               preflight_ok,
  input  wire logic               is_armed,
  input  wire logic signed [15:0] current_down,
  input  wire logic signed [15:0] cmd_vx,
  input  wire logic signed [15:0] cmd_vy,
  input  wire logic signed [15:0] cmd_yaw_rate,
  input  wire logic               q_full,
  output logic                    push,
  output job_t                    job
);

  phase_t             phase, phase_next;
  logic [4:0]         count, count_next;
  logic               have_cmd, have_cmd_next;
  logic [15:0]        age, age_next;
  logic signed [15:0] held_vx, held_vx_next;
  logic signed [15:0] held_vy, held_vy_next;
  logic signed [15:0] held_yr, held_yr_next;

  logic [4:0]         count_inc;
  logic [15:0]        age_inc;
  logic signed [16:0] err;
  logic               near;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  // height error: up-positive target against down-positive odometry
  assign err  = 17'sd0 - $signed({2'b00, cfg.cruise_height}) - {current_down[15], current_down};
  assign near = (err >= -NEAR_LIMIT) && (err <= NEAR_LIMIT);

  assign count_inc = count + 5'd1;
  assign age_inc   = (age == 16'hFFFF) ? age : age + 16'd1;

  // sequencer and command bookkeeping
  always_comb begin
    phase_next    = phase;
    count_next    = count;
    have_cmd_next = have_cmd;
    age_next      = age;
    held_vx_next  = held_vx;
    held_vy_next  = held_vy;
    held_yr_next  = held_yr;

    job.hb  = 1'b0;
    job.sp  = 1'b0;
    job.alt = 1'b0;
    job.vel = 1'b0;
    job.ce  = 1'b0;
    job.ck  = CMD_ARM;
    job.err = err;
    job.vx  = held_vx;
    job.vy  = held_vy;
    job.yr  = held_yr;

    case (mode)
      MODE_SEQ: begin
        case (phase)
          PH_WAIT: begin
            if (preflight_ok) begin
              phase_next = PH_STREAM;
              count_next = 5'd0;
            end
          end
          PH_STREAM: begin
            job.sp     = 1'b1;
            count_next = count_inc;
            if (count_inc >= STREAM_TICKS) begin
              job.ce     = 1'b1;
              job.ck     = CMD_OFFBOARD;
              phase_next = PH_ARM;
              count_next = 5'd0;
            end
          end
          PH_ARM: begin
            job.ce     = 1'b1;
            job.ck     = CMD_ARM;
            count_next = count_inc;
            if (is_armed) begin
              phase_next = PH_CLIMB;
              count_next = 5'd0;
            end else if (count_inc > ARM_TICK_LIMIT) begin
              phase_next = PH_WAIT;
              count_next = 5'd0;
            end
          end
          PH_CLIMB: begin
            if (near) begin
              phase_next = PH_CRUISE;
            end else begin
              job.sp  = 1'b1;
              job.alt = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
      MODE_BEAT: begin
        job.hb   = 1'b1;
        age_next = age_inc;
        if (phase == PH_CRUISE) begin
          job.sp  = 1'b1;
          job.alt = 1'b1;
          job.vel = have_cmd && (age_inc < cfg.cmd_timeout);
        end
      end
      MODE_CMD: begin
        held_vx_next  = cmd_vx;
        held_vy_next  = cmd_vy;
        held_yr_next  = cmd_yaw_rate;
        have_cmd_next = 1'b1;
        age_next      = 16'd0;
      end
      default: begin
      end
    endcase

    job.phase = phase_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_WAIT;
      count    <= 5'd0;
      have_cmd <= 1'b0;
      age      <= 16'd0;
      held_vx  <= 16'sd0;
      held_vy  <= 16'sd0;
      held_yr  <= 16'sd0;
    end else if (push) begin
      phase    <= phase_next;
      count    <= count_next;
      have_cmd <= have_cmd_next;
      age      <= age_next;
      held_vx  <= held_vx_next;
      held_vy  <= held_vy_next;
      held_yr  <= held_yr_next;
    end
  end

  // the tick counter only runs while streaming or arming
  `TSVL_ASSERT_IMPL(a_count_idle, phase == PH_WAIT || phase == PH_CLIMB || phase == PH_CRUISE, count == 5'd0, "tick count nonzero outside streaming and arming")
  `TSVL_ASSERT_IMPL(a_count_bound, 1'b1, count <= ARM_TICK_LIMIT, "tick count past arming limit")

endmodule

`default_nettype wire

FILE: rtl/tsvl_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

`include "takeoff_sequencer_velocity_limiter_unit_defines.svh"

module tsvl_fifo import tsvl_pkg::*; #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t wr_data,
  output logic      full,
  output logic      rd_valid,
  input  wire logic pop,
  output job_t      rd_data
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full     = (count == CNT_W'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  `TSVL_ASSERT_IMPL(a_fill_bound, 1'b1, count <= CNT_W'(DEPTH), "queue fill count past depth")
  `TSVL_ASSERT_NEXT(a_fill_up, do_push && !do_pop, count == $past(count) + CNT_W'(1), "queue fill count missed a push")

endmodule

`default_nettype wire

FILE: rtl/tsvl_back.sv
`timescale 1ns / 1ps
`default_nettype none

`include "takeoff_sequencer_velocity_limiter_unit_defines.svh"

module tsvl_back import tsvl_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cfg_t               cfg,
  input  wire logic               q_valid,
  input  wire job_t               q_data,
  output logic                    q_pop,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    control_mode_emit,
  output logic                    setpoint_emit,
  output logic signed [15:0]      out_vx,
  output logic signed [15:0]      out_vy,
  output logic signed [15:0]      out_vz,
  output logic signed [15:0]      out_yaw_rate,
  output logic                    command_emit,
  output logic                    command_kind,
  output logic [2:0]              phase
);

  // clamp a signed value to +/- an unsigned limit
  function automatic logic signed [15:0] clamp16(logic signed [15:0] v, logic [14:0] lim);
    logic signed [16:0] v17;
    logic signed [16:0] l17;
    logic signed [16:0] r;
    v17 = {v[15], v};
    l17 = $signed({2'b00, lim});
    if (v17 > l17) r = l17;
    else if (v17 < -l17) r = -l17;
    else r = v17;
    return r[15:0];
  endfunction

  function automatic logic signed [15:0] clamp22(logic signed [21:0] v, logic [14:0] lim);
    logic signed [21:0] l22;
    logic signed [21:0] r;
    l22 = $signed({7'd0, lim});
    if (v > l22) r = l22;
    else if (v < -l22) r = -l22;
    else r = v;
    return r[15:0];
  endfunction

  logic               adv;

  // stage 1: multiply and horizontal clamp
  logic               s1_valid;
  logic               s1_hb, s1_sp, s1_alt, s1_ce, s1_ck;
  phase_t             s1_phase;
  logic signed [29:0] s1_prod;
  logic signed [15:0] s1_vx, s1_vy, s1_yr;

  logic signed [29:0] err_ext, gain_ext;
  logic signed [29:0] rounded;
  logic signed [21:0] vz_raw;

  assign adv   = !out_valid || !out_stall;
  assign q_pop = q_valid && adv;

  assign err_ext  = {{13{q_data.err[16]}}, q_data.err};
  assign gain_ext = $signed({18'd0, cfg.height_gain});

  // round half up, then drop the fraction bits of the gain
  assign rounded = s1_prod + ROUND_HALF;
  assign vz_raw  = rounded[29:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      s1_valid  <= q_valid;
      out_valid <= s1_valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_hb    <= q_data.hb;
      s1_sp    <= q_data.sp;
      s1_alt   <= q_data.alt;
      s1_ce    <= q_data.ce;
      s1_ck    <= q_data.ce ? q_data.ck : CMD_ARM;
      s1_phase <= q_data.phase;
      s1_prod  <= err_ext * gain_ext;
      s1_vx    <= q_data.vel ? clamp16(q_data.vx, cfg.max_h_speed) : 16'sd0;
      s1_vy    <= q_data.vel ? clamp16(q_data.vy, cfg.max_h_speed) : 16'sd0;
      s1_yr    <= q_data.vel ? q_data.yr : 16'sd0;
    end
  end

  // stage 2: vertical law and output register
  always_ff @(posedge clk) begin
    if (adv) begin
      control_mode_emit <= s1_hb;
      setpoint_emit     <= s1_sp;
      out_vx            <= s1_sp ? s1_vx : 16'sd0;
      out_vy            <= s1_sp ? s1_vy : 16'sd0;
      out_yaw_rate      <= s1_sp ? s1_yr : 16'sd0;
      out_vz            <= s1_alt ? clamp22(vz_raw, cfg.max_v_speed) : 16'sd0;
      command_emit      <= s1_ce;
      command_kind      <= s1_ck;
      phase             <= s1_phase;
    end
  end

  `TSVL_ASSERT_IMPL(a_quiet_setpoint, out_valid && !setpoint_emit, out_vx == 16'sd0 && out_vy == 16'sd0 && out_vz == 16'sd0 && out_yaw_rate == 16'sd0, "velocity fields set without a setpoint")
  `TSVL_ASSERT_IMPL(a_quiet_command, out_valid && !command_emit, command_kind == CMD_ARM, "command kind set without a command")

endmodule

`default_nettype wire

FILE: rtl/takeoff_sequencer_velocity_limiter_unit.sv
// A word accepted by the front passes the queue, stage 1 and the output register.
// Throughput: one word per cycle while out_stall is low, set by the two-stage back
// pipeline (multiply stage, then round and clamp stage) behind a short queue.
// Reset: rst is synchronous, active high; it returns the sequencer to waiting,
// clears the held command and loads the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module takeoff_sequencer_velocity_limiter_unit import tsvl_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            mode,
  input  wire logic                  preflight_ok,
  input  wire logic                  is_armed,
  input  wire logic signed [15:0]    current_down,
  input  wire logic signed [15:0]    cmd_vx,
  input  wire logic signed [15:0]    cmd_vy,
  input  wire logic signed [15:0]    cmd_yaw_rate,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       control_mode_emit,
  output logic                       setpoint_emit,
  output logic signed [15:0]         out_vx,
  output logic signed [15:0]         out_vy,
  output logic signed [15:0]         out_vz,
  output logic signed [15:0]         out_yaw_rate,
  output logic                       command_emit,
  output logic                       command_kind,
  output logic [2:0]                 phase
);

  cfg_t cfg;
  logic q_full, q_valid, q_pop, push;
  job_t job_in, job_out;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cruise_height <= RST_CRUISE_HEIGHT;
      cfg.max_h_speed   <= RST_MAX_H_SPEED;
      cfg.max_v_speed   <= RST_MAX_V_SPEED;
      cfg.height_gain   <= RST_HEIGHT_GAIN;
      cfg.cmd_timeout   <= RST_CMD_TIMEOUT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CRUISE_HEIGHT: cfg.cruise_height <= cfg_data[14:0];
        REG_MAX_H_SPEED:   cfg.max_h_speed   <= cfg_data[14:0];
        REG_MAX_V_SPEED:   cfg.max_v_speed   <= cfg_data[14:0];
        REG_HEIGHT_GAIN:   cfg.height_gain   <= cfg_data[11:0];
        REG_CMD_TIMEOUT:   cfg.cmd_timeout   <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  tsvl_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .preflight_ok (preflight_ok),
    .is_armed     (is_armed),
    .current_down (current_down),
    .cmd_vx       (cmd_vx),
    .cmd_vy       (cmd_vy),
    .cmd_yaw_rate (cmd_yaw_rate),
    .q_full       (q_full),
    .push         (push),
    .job          (job_in)
  );

  tsvl_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_data  (job_in),
    .full     (q_full),
    .rd_valid (q_valid),
    .pop      (q_pop),
    .rd_data  (job_out)
  );

  tsvl_back u_back (
    .clk               (clk),
    .rst               (rst),
    .cfg               (cfg),
    .q_valid           (q_valid),
    .q_data            (job_out),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .control_mode_emit (control_mode_emit),
    .setpoint_emit     (setpoint_emit),
    .out_vx            (out_vx),
    .out_vy            (out_vy),
    .out_vz            (out_vz),
    .out_yaw_rate      (out_yaw_rate),
    .command_emit      (command_emit),
    .command_kind      (command_kind),
    .phase             (phase)
  );

endmodule

`default_nettype wire

FILE: dv/tsvl_flight_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the take-off sequencer, keeps its own copy of the
// sequencer state and settings, and checks every result word in order.
module tsvl_flight_checker import tsvl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [1:0]            mode,
  input  logic                  preflight_ok,
  input  logic                  is_armed,
  input  logic signed [15:0]    current_down,
  input  logic signed [15:0]    cmd_vx,
  input  logic signed [15:0]    cmd_vy,
  input  logic signed [15:0]    cmd_yaw_rate,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  control_mode_emit,
  input  logic                  setpoint_emit,
  input  logic signed [15:0]    out_vx,
  input  logic signed [15:0]    out_vy,
  input  logic signed [15:0]    out_vz,
  input  logic signed [15:0]    out_yaw_rate,
  input  logic                  command_emit,
  input  logic                  command_kind,
  input  logic [2:0]            phase,
  output int                    mismatches,
  output int                    words_open
);

  typedef struct packed {
    logic               hb;
    logic               sp;
    logic signed [15:0] vx;
    logic signed [15:0] vy;
    logic signed [15:0] vz;
    logic signed [15:0] yr;
    logic               ce;
    logic               ck;
    logic [2:0]         phase;
  } flight_word_t;

  // shadow settings
  logic [14:0] height_set;
  logic [14:0] hspeed_lim;
  logic [14:0] vspeed_lim;
  logic [11:0] gain_set;
  logic [15:0] timeout_set;

  // shadow sequencer state
  phase_t             seq_phase;
  logic [4:0]         tick_count;
  logic               cmd_held;
  logic [15:0]        cmd_age;
  logic signed [15:0] hold_vx;
  logic signed [15:0] hold_vy;
  logic signed [15:0] hold_yr;

  flight_word_t words_due[$];
  int           words_out;

  task automatic note_mismatch(input string field, input longint got, input longint want);
    if (mismatches < 30)
      $display("checker: word %0d %s: got %0d, expected %0d", words_out, field, got, want);
    mismatches++;
  endtask

  function automatic int clamp_to(input int v, input int lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // proportional climb rate, rounded half up, saturated, then clamped
  function automatic int climb_rate(input int err);
    longint prod;
    longint q;
    prod = longint'(err) * longint'(gain_set) + 128;
    q = prod >>> 8;
    if (q > 32767) q = 32767;
    else if (q < -32768) q = -32768;
    return clamp_to(int'(q), int'(vspeed_lim));
  endfunction

  // steps the shadow sequencer by one input word and returns its result word
  function automatic flight_word_t next_flight_word(
      input logic [1:0] m, input logic pf, input logic ar,
      input logic signed [15:0] dn, input logic signed [15:0] vx,
      input logic signed [15:0] vy, input logic signed [15:0] yr);
    flight_word_t w;
    int err;
    int mag;
    w = '0;
    err = -int'(height_set) - int'(dn);
    mag = (err < 0) ? -err : err;
    if (seq_phase > PH_CRUISE) seq_phase = PH_WAIT;
    case (m)
      MODE_SEQ: begin
        case (seq_phase)
          PH_WAIT: begin
            if (pf) begin
              seq_phase = PH_STREAM;
              tick_count = '0;
            end
          end
          PH_STREAM: begin
            w.sp = 1'b1;
            tick_count = tick_count + 5'd1;
            if (tick_count >= STREAM_TICKS) begin
              w.ce = 1'b1;
              w.ck = CMD_OFFBOARD;
              seq_phase = PH_ARM;
              tick_count = '0;
            end
          end
          PH_ARM: begin
            w.ce = 1'b1;
            w.ck = CMD_ARM;
            tick_count = tick_count + 5'd1;
            if (ar) begin
              seq_phase = PH_CLIMB;
              tick_count = '0;
            end else if (tick_count > ARM_TICK_LIMIT) begin
              seq_phase = PH_WAIT;
              tick_count = '0;
            end
          end
          PH_CLIMB: begin
            // close enough: switch to cruise, no setpoint this word
            if (mag <= NEAR_LIMIT) begin
              seq_phase = PH_CRUISE;
            end else begin
              w.sp = 1'b1;
              w.vz = 16'(climb_rate(err));
            end
          end
          default: ;
        endcase
      end
      MODE_BEAT: begin
        w.hb = 1'b1;
        if (cmd_age != 16'hFFFF) cmd_age = cmd_age + 16'd1;
        if (seq_phase == PH_CRUISE) begin
          w.sp = 1'b1;
          // stale or missing command means hover
          if (cmd_held && cmd_age < timeout_set) begin
            w.vx = 16'(clamp_to(int'(hold_vx), int'(hspeed_lim)));
            w.vy = 16'(clamp_to(int'(hold_vy), int'(hspeed_lim)));
            w.yr = hold_yr;
          end
          w.vz = 16'(climb_rate(err));
        end
      end
      MODE_CMD: begin
        hold_vx = vx;
        hold_vy = vy;
        hold_yr = yr;
        cmd_held = 1'b1;
        cmd_age = '0;
      end
      default: ;
    endcase
    w.phase = seq_phase;
    return w;
  endfunction

  // compare outgoing words, track settings, predict incoming words
  always @(posedge clk) begin : watch
    flight_word_t want;
    if (rst) begin
      height_set  = RST_CRUISE_HEIGHT;
      hspeed_lim  = RST_MAX_H_SPEED;
      vspeed_lim  = RST_MAX_V_SPEED;
      gain_set    = RST_HEIGHT_GAIN;
      timeout_set = RST_CMD_TIMEOUT;
      seq_phase   = PH_WAIT;
      tick_count  = '0;
      cmd_held    = 1'b0;
      cmd_age     = '0;
      hold_vx     = '0;
      hold_vy     = '0;
      hold_yr     = '0;
      words_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (words_due.size() == 0) begin
          note_mismatch("word with none pending", 1, 0);
        end else begin
          want = words_due.pop_front();
          if (control_mode_emit !== want.hb)
            note_mismatch("control_mode_emit", control_mode_emit, want.hb);
          if (setpoint_emit !== want.sp)
            note_mismatch("setpoint_emit", setpoint_emit, want.sp);
          if (out_vx !== want.vx) note_mismatch("out_vx", out_vx, want.vx);
          if (out_vy !== want.vy) note_mismatch("out_vy", out_vy, want.vy);
          if (out_vz !== want.vz) note_mismatch("out_vz", out_vz, want.vz);
          if (out_yaw_rate !== want.yr) note_mismatch("out_yaw_rate", out_yaw_rate, want.yr);
          if (command_emit !== want.ce) note_mismatch("command_emit", command_emit, want.ce);
          if (command_kind !== want.ck) note_mismatch("command_kind", command_kind, want.ck);
          if (phase !== want.phase) note_mismatch("phase", phase, want.phase);
        end
        words_out++;
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_CRUISE_HEIGHT: height_set  = cfg_data[14:0];
          REG_MAX_H_SPEED:   hspeed_lim  = cfg_data[14:0];
          REG_MAX_V_SPEED:   vspeed_lim  = cfg_data[14:0];
          REG_HEIGHT_GAIN:   gain_set    = cfg_data[11:0];
          REG_CMD_TIMEOUT:   timeout_set = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        words_due.push_back(next_flight_word(mode, preflight_ok, is_armed, current_down,
                                             cmd_vx, cmd_vy, cmd_yaw_rate));
    end
    words_open = words_due.size();
  end

endmodule

FILE: dv/tb.sv
`timescale 1ns / 1ps

module tb import tsvl_pkg::*;;

  // mode code the block ignores
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [1:0]            mode;
  logic                  preflight_ok;
  logic                  is_armed;
  logic signed [15:0]    current_down;
  logic signed [15:0]    cmd_vx;
  logic signed [15:0]    cmd_vy;
  logic signed [15:0]    cmd_yaw_rate;
  logic                  out_valid;
  logic                  out_stall;
  logic                  control_mode_emit;
  logic                  setpoint_emit;
  logic signed [15:0]    out_vx;
  logic signed [15:0]    out_vy;
  logic signed [15:0]    out_vz;
  logic signed [15:0]    out_yaw_rate;
  logic                  command_emit;
  logic                  command_kind;
  logic [2:0]            phase;

  int mismatches;
  int words_open;

  // stimulus shaping
  bit calm = 1'b0;      // no idling on either side
  bit hold_req = 1'b0;  // asks the receiver for one long hold-off
  int hold_left = 0;
  int cur_height = 768;
  int cur_hlim = 512;

  always #5 clk = ~clk;

  takeoff_sequencer_velocity_limiter_unit uut (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .mode, .preflight_ok, .is_armed, .current_down,
    .cmd_vx, .cmd_vy, .cmd_yaw_rate,
    .out_valid, .out_stall, .control_mode_emit, .setpoint_emit,
    .out_vx, .out_vy, .out_vz, .out_yaw_rate, .command_emit, .command_kind, .phase
  );

  tsvl_flight_checker flight_check (
    .clk, .rst, .cfg_write, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .mode, .preflight_ok, .is_armed, .current_down,
    .cmd_vx, .cmd_vy, .cmd_yaw_rate,
    .out_valid, .out_stall, .control_mode_emit, .setpoint_emit,
    .out_vx, .out_vy, .out_vz, .out_yaw_rate, .command_emit, .command_kind, .phase,
    .mismatches, .words_open
  );

  // run limit
  initial begin
    #3_000_000;
    $display("tb: done, errors");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin : receiver
    int burst;
    burst = 0;
    out_stall <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 80;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (burst > 0) begin
        burst--;
      end else begin
        out_stall <= ($urandom_range(0, 2) == 0);
        burst = $urandom_range(1, 14) - 1;
      end
    end
  end

  // offer one word, return at the falling edge after it is taken
  task automatic send_word(input logic [1:0] m, input logic pf, input logic ar,
                           input logic signed [15:0] dn, input logic signed [15:0] vx,
                           input logic signed [15:0] vy, input logic signed [15:0] yr);
    if (!calm && !hold_req && hold_left == 0 && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    preflight_ok <= pf;
    is_armed     <= ar;
    current_down <= dn;
    cmd_vx       <= vx;
    cmd_vy       <= vy;
    cmd_yaw_rate <= yr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // drop valid and wait until every predicted word has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (words_open != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(negedge clk);
  endtask

  // all five registers; unused upper data bits carry junk
  task automatic program_settings(input logic [14:0] h, input logic [14:0] hl,
                                  input logic [14:0] vl, input logic [11:0] g,
                                  input logic [15:0] t);
    write_reg(REG_CRUISE_HEIGHT, {1'($urandom), h});
    write_reg(REG_MAX_H_SPEED, {1'($urandom), hl});
    write_reg(REG_MAX_V_SPEED, {1'($urandom), vl});
    write_reg(REG_HEIGHT_GAIN, {4'($urandom), g});
    write_reg(REG_CMD_TIMEOUT, t);
    cfg_write <= 1'b0;
    cur_height = int'(h);
    cur_hlim = int'(hl);
  endtask

  // altitude: near the cruise height, just past the edge of the band, at an extreme, or anywhere
  function automatic logic signed [15:0] pick_down(input int near_pct);
    int r, v;
    r = $urandom_range(0, 99);
    if (r < near_pct) begin
      v = -cur_height + int'($urandom_range(0, 160)) - 80;
    end else if (r < near_pct + 12) begin
      case ($urandom_range(0, 3))
        0: v = -cur_height - 77;
        1: v = -cur_height + 77;
        2: v = -32768;
        default: v = 32767;
      endcase
    end else begin
      v = int'($signed(16'($urandom)));
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  // velocity: extremes, zero or minus one, around the clamp limit, or anywhere
  function automatic logic signed [15:0] pick_speed();
    int r, v;
    r = $urandom_range(0, 9);
    if (r < 2) begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = -1;
      endcase
    end else if (r < 5) begin
      v = cur_hlim + int'($urandom_range(0, 4)) - 2;
      if ($urandom_range(0, 1) == 0) v = -v;
    end else begin
      v = int'($signed(16'($urandom)));
    end
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  task automatic run_random(input int count, input int armed_pct, input int near_pct,
                            input int seq_pct);
    int r;
    logic [1:0] m;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < seq_pct) begin
        m = MODE_SEQ;
      end else begin
        r = $urandom_range(0, 99);
        m = (r < 60) ? MODE_BEAT : (r < 95) ? MODE_CMD : MODE_UNUSED;
      end
      send_word(m, $urandom_range(0, 99) < 85, $urandom_range(0, 99) < armed_pct,
                pick_down(near_pct), pick_speed(), pick_speed(), pick_speed());
    end
  endtask

  initial begin : stimulus
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    mode         <= MODE_SEQ;
    preflight_ok <= 1'b0;
    is_armed     <= 1'b0;
    current_down <= '0;
    cmd_vx       <= '0;
    cmd_vy       <= '0;
    cmd_yaw_rate <= '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed: wait, ignored mode, command extremes, full stream, arming
    send_word(MODE_BEAT, 1'b0, 1'b0, 16'sh0000, 16'sh0100, 16'sh0100, 16'sh0100);
    send_word(MODE_UNUSED, 1'b1, 1'b1, 16'shFFFF, 16'shFFFF, 16'shFFFF, 16'shFFFF);
    send_word(MODE_CMD, 1'b0, 1'b0, 16'sh0000, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_word(MODE_SEQ, 1'b0, 1'b1, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(MODE_SEQ, 1'b1, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(MODE_BEAT, 1'b1, 1'b0, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(MODE_CMD, 1'b1, 1'b0, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF);
    // ten streaming ticks, the last one requests offboard
    for (int i = 0; i < 10; i++)
      send_word(MODE_SEQ, 1'(i % 2), 1'(i == 3), 16'sh8000, 16'sh0000, 16'sh0000,
                16'sh0000);
    send_word(MODE_SEQ, 1'b1, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(MODE_BEAT, 1'b1, 1'b0, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000);
    send_word(MODE_SEQ, 1'b0, 1'b0, 16'sh7FFF, 16'sh0000, 16'sh0000, 16'sh0000);

    // arming rarely succeeds and climbing rarely ends: retries and give-ups
    settle();
    program_settings(15'd768, 15'd512, 15'd256, 12'd128, 16'd20);
    run_random(260, 2, 0, 70);

    // extremes, and a push into cruise
    settle();
    program_settings(15'd0, 15'd0, 15'd32767, 12'd4095, 16'd1);
    run_random(180, 50, 40, 50);

    // other extremes, with one long receiver hold-off while words keep coming
    settle();
    program_settings(15'd32767, 15'd32767, 15'd0, 12'd0, 16'd65535);
    hold_req = 1'b1;
    run_random(180, 40, 40, 40);

    // random settings, zero timeout
    settle();
    program_settings(15'($urandom), 15'($urandom), 15'($urandom), 12'($urandom), 16'd0);
    run_random(180, 40, 30, 40);

    // random settings, short timeouts
    settle();
    program_settings(15'($urandom), 15'($urandom), 15'($urandom), 12'($urandom),
                     16'($urandom_range(1, 40)));
    run_random(180, 40, 30, 30);

    // moderate settings, commands go stale often; second half without idling
    settle();
    program_settings(15'($urandom_range(256, 2048)), 15'($urandom_range(64, 1024)),
                     15'($urandom_range(64, 1024)), 12'($urandom_range(16, 512)),
                     16'($urandom_range(1, 8)));
    run_random(90, 40, 30, 30);
    calm = 1'b1;
    run_random(90, 40, 30, 30);

    // drain, then keep the clock running to catch stray words
    settle();
    repeat (8) @(negedge clk);
    if (mismatches == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/tsvl_pkg.sv
rtl/tsvl_front.sv
rtl/tsvl_fifo.sv
rtl/tsvl_back.sv
rtl/takeoff_sequencer_velocity_limiter_unit.sv
dv/tsvl_flight_checker.sv
dv/tb.sv
